### sv/cascaded_tpt_svf_core_assert.svh
// assertion macros used by the port checker file
`ifndef CASCADED_TPT_SVF_CORE_ASSERT_SVH
`define CASCADED_TPT_SVF_CORE_ASSERT_SVH

// plain property checked on every rising clock edge outside reset
`define TSVF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent followed by consequent in the next cycle
`define TSVF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/tsvf_pkg.sv
// ----------------------------------------------------------------------------
// tsvf_pkg
// shared constants, register codes and the microcode table of the filter core
// ----------------------------------------------------------------------------
`default_nettype none

package tsvf_pkg;

    localparam int MAX_STAGES = 8;
    localparam int CHANNELS   = 2;
    localparam int SLOTS      = MAX_STAGES * CHANNELS;
    localparam int STAGE_W    = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int SAMPLE_W = 24;
    localparam int STATE_W  = 32;
    localparam int CFG_W    = 25;
    localparam int CIDX_W   = 3;
    localparam int UC_W     = 3;

    localparam int Q24_ONE = 1 << 24;

    // register indexes
    localparam logic [CIDX_W-1:0] CFG_STAGES = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_MODE   = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_G      = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_R      = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_H      = 3'd4;

    // response modes
    localparam logic [1:0] MODE_LP    = 2'd0;
    localparam logic [1:0] MODE_BP    = 2'd1;
    localparam logic [1:0] MODE_HP    = 2'd2;
    localparam logic [1:0] MODE_NOTCH = 2'd3;

    // register reset values
    localparam logic [3:0]  RST_STAGES = 4'd1;
    localparam logic [1:0]  RST_MODE   = MODE_LP;
    localparam logic [23:0] RST_G      = 24'd1048576;
    localparam logic [23:0] RST_R      = 24'd741455;
    localparam logic [24:0] RST_H      = 25'd4914615;

    // multiplier operand pairs
    typedef enum logic [1:0] {
        MS_KS1 = 2'd0,
        MS_PH  = 2'd1,
        MS_GHP = 2'd2,
        MS_GBP = 2'd3
    } t_mul_src;

    typedef enum logic {
        JMP_NEXT = 1'b0,
        JMP_LOOP = 1'b1
    } t_jump;

    typedef struct packed {
        logic     mul_en;
        t_mul_src mul_src;
        logic     ld_state;
        logic     ld_pre;
        logic     ld_hp;
        logic     ld_bp;
        logic     ld_out;
        t_jump    jmp;
    } t_ctrl;

    // one stage of the filter, eight control words
    function automatic t_ctrl ucode(input logic [UC_W-1:0] step);
        t_ctrl w;
        w = '0;
        case (step)
            3'd0: begin
                w.mul_en   = 1'b1;
                w.mul_src  = MS_KS1;
                w.ld_state = 1'b1;
            end
            3'd1: w.ld_pre = 1'b1;
            3'd2: begin
                w.mul_en  = 1'b1;
                w.mul_src = MS_PH;
            end
            3'd3: w.ld_hp = 1'b1;
            3'd4: begin
                w.mul_en  = 1'b1;
                w.mul_src = MS_GHP;
            end
            3'd5: w.ld_bp = 1'b1;
            3'd6: begin
                w.mul_en  = 1'b1;
                w.mul_src = MS_GBP;
            end
            3'd7: begin
                w.ld_out = 1'b1;
                w.jmp    = JMP_LOOP;
            end
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### sv/tsvf_seq.sv
// ----------------------------------------------------------------------------
// tsvf_seq
// microcode sequencer: step counter, stage counter, handshake and control word
// ----------------------------------------------------------------------------
`default_nettype none

module tsvf_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [0:0]                  i_channel_index,
    input  logic [3:0]                  i_stages,
    input  logic                        i_out_free,
    output logic                        o_start,
    output logic                        o_out_load,
    output logic [tsvf_pkg::SLOT_W-1:0] o_slot,
    output tsvf_pkg::t_ctrl             o_ctrl
);
    import tsvf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [UC_W-1:0]     r_step, n_step;
    logic [STAGE_W-1:0]  r_stage, n_stage;
    logic [CH_W-1:0]     r_ch, n_ch;
    logic [5:0]          n_eff;
    logic                last_stage;

    assign n_eff = (6'(i_stages) > 6'(MAX_STAGES)) ? 6'(MAX_STAGES) : 6'(i_stages);
    assign last_stage = ((6'(r_stage) + 6'd1) == n_eff);

    assign o_ctrl     = (r_state == ST_RUN) ? ucode(r_step) : '0;
    assign o_in_ready = (r_state == ST_IDLE);
    assign o_start    = o_in_ready & i_in_valid;
    assign o_out_load = (r_state == ST_DONE) & i_out_free;
    assign o_slot     = SLOT_W'(int'(r_stage) * CHANNELS + int'(r_ch));

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_stage = r_stage;
        n_ch    = r_ch;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_ch    = CH_W'(int'(i_channel_index) % CHANNELS);
                    n_stage = '0;
                    n_step  = '0;
                    n_state = (i_stages == 4'd0) ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN: begin
                if (o_ctrl.jmp == JMP_LOOP) begin
                    if (last_stage) begin
                        n_state = ST_DONE;
                    end else begin
                        n_stage = r_stage + 1'b1;
                        n_step  = '0;
                    end
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_stage <= '0;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_stage <= n_stage;
            r_ch    <= n_ch;
        end
    end

endmodule

`default_nettype wire

### sv/tsvf_dp.sv
// ----------------------------------------------------------------------------
// tsvf_dp
// filter datapath: shared multiplier, rounding, saturation and state store
// ----------------------------------------------------------------------------
`default_nettype none

module tsvf_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tsvf_pkg::t_ctrl                    i_ctrl,
    input  logic                               i_start,
    input  logic signed [tsvf_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [tsvf_pkg::SLOT_W-1:0]        i_slot,
    input  logic [23:0]                        i_g,
    input  logic [25:0]                        i_k,
    input  logic [24:0]                        i_h,
    input  logic [1:0]                         i_mode,
    output logic signed [tsvf_pkg::SAMPLE_W-1:0] o_result
);
    import tsvf_pkg::*;

    localparam logic signed [47:0] SAT_MAX = 48'sd2147483647;
    localparam logic signed [47:0] SAT_MIN = -48'sd2147483648;
    localparam logic signed [66:0] HALF20  = 67'sd524288;
    localparam logic signed [66:0] HALF24  = 67'sd8388608;
    localparam logic signed [32:0] OUT_MAX = 33'sd8388607;
    localparam logic signed [32:0] OUT_MIN = -33'sd8388608;

    function automatic logic signed [STATE_W-1:0] sat32(input logic signed [47:0] v);
        logic signed [STATE_W-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[STATE_W-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[STATE_W-1:0];
        end else begin
            r = v[STATE_W-1:0];
        end
        return r;
    endfunction

    logic signed [STATE_W-1:0] r_int1 [SLOTS];
    logic signed [STATE_W-1:0] r_int2 [SLOTS];

    logic signed [STATE_W-1:0] r_sig, r_s1, r_s2, r_hp, r_bp;
    logic signed [39:0]        r_pre, r_ghp;
    logic signed [66:0]        r_prod;

    logic signed [39:0]        mul_a;
    logic [25:0]               mul_b;
    logic signed [26:0]        mul_b_s;
    logic signed [47:0]        rnd20, rnd24, pre_sum;
    logic signed [STATE_W-1:0] lp, s1_new, s2_new, notch, sig_sel;
    logic signed [47:0]        gbp;
    logic signed [32:0]        out_rnd;

    always_comb begin
        case (i_ctrl.mul_src)
            MS_KS1: begin
                mul_a = 40'(r_int1[i_slot]);
                mul_b = i_k;
            end
            MS_PH: begin
                mul_a = r_pre;
                mul_b = 26'(i_h);
            end
            MS_GHP: begin
                mul_a = 40'(r_hp);
                mul_b = 26'(i_g);
            end
            default: begin
                mul_a = 40'(r_bp);
                mul_b = 26'(i_g);
            end
        endcase
    end

    assign mul_b_s = {1'b0, mul_b};

    assign rnd20   = 48'((r_prod + HALF20) >>> 20);
    assign rnd24   = 48'((r_prod + HALF24) >>> 24);
    assign pre_sum = 48'(r_sig) - rnd20 - 48'(r_s2);

    assign gbp    = rnd20;
    assign lp     = sat32(gbp + 48'(r_s2));
    assign s1_new = sat32(48'(r_ghp) + 48'(r_bp));
    assign s2_new = sat32(gbp + 48'(lp));
    assign notch  = sat32(48'(lp) + 48'(r_hp));

    always_comb begin
        case (i_mode)
            MODE_LP: sig_sel = lp;
            MODE_BP: sig_sel = r_bp;
            MODE_HP: sig_sel = r_hp;
            default: sig_sel = notch;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= mul_a * mul_b_s;
        end
        if (i_ctrl.ld_state) begin
            r_s1 <= r_int1[i_slot];
            r_s2 <= r_int2[i_slot];
        end
        if (i_ctrl.ld_pre) begin
            r_pre <= 40'(pre_sum);
        end
        if (i_ctrl.ld_hp) begin
            r_hp <= sat32(rnd24);
        end
        if (i_ctrl.ld_bp) begin
            r_ghp <= 40'(rnd20);
            r_bp  <= sat32(rnd20 + 48'(r_s1));
        end
        if (i_start) begin
            r_sig <= {{(STATE_W-SAMPLE_W-1){i_sample[SAMPLE_W-1]}}, i_sample, 1'b0};
        end else if (i_ctrl.ld_out) begin
            r_sig <= sig_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_int1[i] <= '0;
                r_int2[i] <= '0;
            end
        end else if (i_ctrl.ld_out) begin
            r_int1[i_slot] <= s1_new;
            r_int2[i_slot] <= s2_new;
        end
    end

    assign out_rnd = (33'(r_sig) + 33'sd1) >>> 1;

    always_comb begin
        if (out_rnd > OUT_MAX) begin
            o_result = OUT_MAX[SAMPLE_W-1:0];
        end else if (out_rnd < OUT_MIN) begin
            o_result = OUT_MIN[SAMPLE_W-1:0];
        end else begin
            o_result = out_rnd[SAMPLE_W-1:0];
        end
    end

endmodule

`default_nettype wire

### sv/cascaded_tpt_svf_core.sv
// ----------------------------------------------------------------------------
// cascaded_tpt_svf_core
// cascade of up to eight two-pole state-variable filter stages, two channels
// ----------------------------------------------------------------------------
// One sample at a time: a beat is taken only while the core is idle. Each
// stage runs eight microcode steps through one shared 40x27 multiplier, and a
// sample holds the core until its last active stage is done and its result is
// loaded into the output register, where it waits while the next sample is
// taken. Configuration is written only while idle: the user must keep to it.
// ----------------------------------------------------------------------------
`default_nettype none

module cascaded_tpt_svf_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [tsvf_pkg::CIDX_W-1:0]          i_cfg_idx,
    input  logic [tsvf_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [0:0]                           i_channel_index,
    input  logic signed [tsvf_pkg::SAMPLE_W-1:0] i_sample_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [tsvf_pkg::SAMPLE_W-1:0] o_sample_out
);
    import tsvf_pkg::*;

    logic [3:0]  r_stages;
    logic [1:0]  r_mode;
    logic [23:0] r_g, r_r;
    logic [25:0] r_k;
    logic [24:0] r_h;

    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out;

    logic                       out_free, start, out_load;
    logic [SLOT_W-1:0]          slot;
    t_ctrl                      ctrl;
    logic signed [SAMPLE_W-1:0] result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stages <= RST_STAGES;
            r_mode   <= RST_MODE;
            r_g      <= RST_G;
            r_r      <= RST_R;
            r_k      <= {RST_R, 1'b0} + 26'(RST_G);
            r_h      <= RST_H;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STAGES: r_stages <= i_cfg_data[3:0];
                CFG_MODE:   r_mode   <= i_cfg_data[1:0];
                CFG_G: begin
                    r_g <= i_cfg_data[23:0];
                    r_k <= {r_r, 1'b0} + 26'(i_cfg_data[23:0]);
                end
                CFG_R: begin
                    r_r <= i_cfg_data[23:0];
                    r_k <= {i_cfg_data[23:0], 1'b0} + 26'(r_g);
                end
                CFG_H: r_h <= (i_cfg_data > 25'(Q24_ONE)) ? 25'(Q24_ONE) : i_cfg_data;
                default: ;
            endcase
        end
    end

    // output register
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;

    tsvf_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_channel_index(i_channel_index),
        .i_stages       (r_stages),
        .i_out_free     (out_free),
        .o_start        (start),
        .o_out_load     (out_load),
        .o_slot         (slot),
        .o_ctrl         (ctrl)
    );

    tsvf_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .i_start (start),
        .i_sample(i_sample_in),
        .i_slot  (slot),
        .i_g     (r_g),
        .i_k     (r_k),
        .i_h     (r_h),
        .i_mode  (r_mode),
        .o_result(result)
    );

endmodule

`default_nettype wire

### sv/tsvf_checker.sv
// ----------------------------------------------------------------------------
// tsvf_checker
// port-level checks of the filter core, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "cascaded_tpt_svf_core_assert.svh"

module tsvf_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_ready,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input logic signed [tsvf_pkg::SAMPLE_W-1:0] o_sample_out
);

    // one sample in flight: a taken beat closes the input
    `TSVF_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "input open right after a beat was taken")

    // input only closes because a beat was taken
    `TSVF_ASSERT(a_ready_falls_on_accept, i_clk, i_rst_n, $fell(o_in_ready) |-> $past(i_in_valid), "input closed without a beat")

    // a new result appears only at the end of busy time
    `TSVF_ASSERT(a_result_after_busy, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(!o_in_ready), "result appeared while idle")

    // stalled result holds
    `TSVF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_sample_out), "stalled output beat changed")

endmodule

bind cascaded_tpt_svf_core tsvf_checker u_tsvf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_sample_out(o_sample_out)
);

`default_nettype wire

### tb/sv/svf_response_checker.sv
// ----------------------------------------------------------------------------
// svf_response_checker
// watches the register port and both beat channels of the filter core, keeps
// its own copy of the cascade state and settings, computes the filtered
// sample of every accepted input beat and compares it with each output beat
// ----------------------------------------------------------------------------

module svf_response_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [tsvf_pkg::CIDX_W-1:0]          i_cfg_idx,
    input  logic [tsvf_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_ready,
    input  logic [0:0]                           i_channel_index,
    input  logic signed [tsvf_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_ready,
    input  logic signed [tsvf_pkg::SAMPLE_W-1:0] i_sample_out,
    output int                                   o_mismatches,
    output int                                   o_pending,
    output int                                   o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import tsvf_pkg::*;

    localparam longint Q824_MAX = 2147483647;
    localparam longint Q824_MIN = -Q824_MAX - 1;
    localparam longint OUT_MAX  = 8388607;
    localparam longint OUT_MIN  = -OUT_MAX - 1;
    localparam int     SHOWN    = 10;

    logic [3:0]                 n_stages;
    logic [1:0]                 resp_sel;
    logic [23:0]                g_coef;
    logic [23:0]                r_damp;
    logic [24:0]                h_norm;
    logic signed [STATE_W-1:0]  s1_mem [SLOTS];
    logic signed [STATE_W-1:0]  s2_mem [SLOTS];
    logic signed [SAMPLE_W-1:0] filtered_q [$];
    logic signed [SAMPLE_W-1:0] want;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    // round half up, then drop n fraction bits
    function automatic longint rnd_shr(longint v, int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clip_q824(longint v);
        if (v > Q824_MAX) return Q824_MAX;
        if (v < Q824_MIN) return Q824_MIN;
        return v;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] filter_sample(
        logic [0:0] ch, logic signed [SAMPLE_W-1:0] x);
        longint      sig, g, k, h, s1, s2, pre, hp, ghp, bp, gbp, lp, res;
        int unsigned depth, slot;
        g     = g_coef;
        k     = 2 * longint'(r_damp) + g;
        h     = h_norm;
        sig   = x;
        sig   = sig * 2;
        depth = (n_stages > MAX_STAGES) ? MAX_STAGES : n_stages;
        for (int unsigned st = 0; st < depth; st++) begin
            slot = st * CHANNELS + (ch % CHANNELS);
            s1   = s1_mem[slot];
            s2   = s2_mem[slot];
            pre  = sig - rnd_shr(k * s1, 20) - s2;
            hp   = clip_q824(rnd_shr(pre * h, 24));
            ghp  = rnd_shr(g * hp, 20);
            bp   = clip_q824(ghp + s1);
            gbp  = rnd_shr(g * bp, 20);
            lp   = clip_q824(gbp + s2);
            s1_mem[slot] = STATE_W'(clip_q824(ghp + bp));
            s2_mem[slot] = STATE_W'(clip_q824(gbp + lp));
            case (resp_sel)
                MODE_LP: sig = lp;
                MODE_BP: sig = bp;
                MODE_HP: sig = hp;
                default: sig = clip_q824(lp + hp);
            endcase
        end
        res = rnd_shr(sig, 1);
        if (res > OUT_MAX) res = OUT_MAX;
        if (res < OUT_MIN) res = OUT_MIN;
        return SAMPLE_W'(res);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            n_stages = RST_STAGES;
            resp_sel = RST_MODE;
            g_coef   = RST_G;
            r_damp   = RST_R;
            h_norm   = RST_H;
            foreach (s1_mem[i]) begin
                s1_mem[i] = '0;
                s2_mem[i] = '0;
            end
            filtered_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_STAGES: n_stages = i_cfg_data[3:0];
                    CFG_MODE:   resp_sel = i_cfg_data[1:0];
                    CFG_G:      g_coef   = i_cfg_data[23:0];
                    CFG_R:      r_damp   = i_cfg_data[23:0];
                    CFG_H:      h_norm   = (i_cfg_data > Q24_ONE) ? 25'(Q24_ONE) : i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (filtered_q.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= SHOWN)
                        $display("%0t: output beat %0d with nothing outstanding",
                                 $realtime, i_sample_out);
                end else begin
                    want = filtered_q.pop_front();
                    o_checked++;
                    if (i_sample_out !== want) begin
                        o_mismatches++;
                        if (o_mismatches <= SHOWN)
                            $display("%0t: sample_out expected %0d, got %0d",
                                     $realtime, want, i_sample_out);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                filtered_q.push_back(filter_sample(i_channel_index, i_sample_in));
        end
        o_pending = filtered_q.size();
    end

endmodule

### tb/sv/cascaded_tpt_svf_core_tb.sv
// ----------------------------------------------------------------------------
// cascaded_tpt_svf_core_tb
// drives the filter core with directed and random samples over many settings
// ----------------------------------------------------------------------------
// A short directed run covers sample extremes, every response, zero and
// oversized stage counts, coefficient extremes, clamped h and unused register
// indexes. Random phases follow, mostly with stable coefficient sets and a
// few with raw register values, under three sender/receiver stall profiles.
// The checker beside the core predicts and compares every output beat.
// ----------------------------------------------------------------------------

module cascaded_tpt_svf_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsvf_pkg::*;

    localparam longint RUN_LIMIT_NS = 2_000_000;
    localparam int     QUIET_CYCLES = 4;
    localparam int     TAIL_CYCLES  = 8 * MAX_STAGES + 16;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

    logic                       clk        = 1'b0;
    logic                       rst_n      = 1'b0;
    logic                       cfg_we     = 1'b0;
    logic [CIDX_W-1:0]          cfg_idx    = '0;
    logic [CFG_W-1:0]           cfg_data   = '0;
    logic                       in_valid   = 1'b0;
    logic                       in_ready;
    logic [0:0]                 channel    = '0;
    logic signed [SAMPLE_W-1:0] sample_in  = '0;
    logic                       out_valid;
    logic                       out_ready  = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_out;

    int          mismatches;
    int          pending;
    int          checked;
    int unsigned send_idle = 0;
    int unsigned recv_idle = 0;
    int unsigned sent      = 0;
    int unsigned writes    = 0;

    cascaded_tpt_svf_core u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_channel_index (channel),
        .i_sample_in     (sample_in),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_sample_out    (sample_out)
    );

    svf_response_checker u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_channel_index (channel),
        .i_sample_in     (sample_in),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_sample_out    (sample_out),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    always #1 clk = ~clk;

    always @(negedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // one input beat, held until taken
    task automatic send_beat(logic [0:0] ch, logic signed [SAMPLE_W-1:0] x);
        while ($urandom_range(0, 99) < send_idle) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        channel   <= ch;
        sample_in <= x;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        sent++;
    endtask

    // stop sending and wait until every output beat is back
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we   <= 1'b0;
        @(negedge clk);
        writes++;
    endtask

    task automatic run_phase(int unsigned count);
        logic [3:0]                 stg;
        logic [23:0]                gq;
        logic [23:0]                rq;
        logic [24:0]                hq;
        logic signed [SAMPLE_W-1:0] x;
        real                        gr;
        real                        rr;
        if ($urandom_range(0, 9) < 8) begin
            // stable coefficient set with matching normalizer
            stg = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(1, MAX_STAGES));
            gr  = $urandom_range(5, 3000) / 1000.0;
            rr  = $urandom_range(50, 2000) / 1000.0;
            gq  = 24'($rtoi(gr * 1048576.0));
            rq  = 24'($rtoi(rr * 1048576.0));
            hq  = 25'($rtoi(16777216.0 / (1.0 + 2.0 * rr * gr + gr * gr) + 0.5));
        end else begin
            stg = 4'($urandom);
            gq  = 24'($urandom);
            rq  = 24'($urandom);
            hq  = 25'($urandom);
        end
        settle();
        write_reg(CFG_STAGES, CFG_W'(stg));
        write_reg(CFG_MODE, CFG_W'($urandom_range(0, 3)));
        write_reg(CFG_G, CFG_W'(gq));
        write_reg(CFG_R, CFG_W'(rq));
        write_reg(CFG_H, hq);
        if ($urandom_range(0, 3) == 0)
            write_reg(CIDX_W'(CFG_H + $urandom_range(1, 3)), CFG_W'($urandom));
        repeat (count) begin
            if ($urandom_range(0, 39) == 0)
                settle();
            case ($urandom_range(0, 9))
                0:       x = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
                1, 2, 3: x = SAMPLE_W'(int'($urandom_range(0, 131071)) - 65536);
                default: x = SAMPLE_W'($urandom);
            endcase
            send_beat(1'($urandom_range(0, 1)), x);
        end
    endtask

    initial begin
        #(RUN_LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle = 17;
        recv_idle = 50;

        // reset settings, both channels, sample extremes
        send_beat(1'b0, SAMPLE_MAX);
        send_beat(1'b1, SAMPLE_MIN);
        send_beat(1'b0, '0);
        send_beat(1'b1, SAMPLE_MAX);
        send_beat(1'b1, -24'sd1);
        settle();
        write_reg(CFG_MODE, CFG_W'(MODE_BP));
        send_beat(1'b0, SAMPLE_MIN);
        settle();
        write_reg(CFG_MODE, CFG_W'(MODE_HP));
        send_beat(1'b1, SAMPLE_MAX);
        settle();
        write_reg(CFG_MODE, CFG_W'(MODE_NOTCH));
        send_beat(1'b0, SAMPLE_MAX);
        // no stage: straight through
        settle();
        write_reg(CFG_STAGES, '0);
        send_beat(1'b0, SAMPLE_MIN);
        send_beat(1'b1, SAMPLE_MAX);
        // stage count beyond the cascade length
        settle();
        write_reg(CFG_STAGES, CFG_W'(4'hF));
        send_beat(1'b1, SAMPLE_MIN);
        send_beat(1'b0, 24'sh123456);
        settle();
        write_reg(CFG_STAGES, CFG_W'(MAX_STAGES));
        write_reg(CFG_MODE, CFG_W'(MODE_LP));
        send_beat(1'b0, SAMPLE_MAX);
        // coefficient extremes
        settle();
        write_reg(CFG_G, '0);
        send_beat(1'b1, SAMPLE_MAX);
        settle();
        write_reg(CFG_G, CFG_W'(24'hFFFFFF));
        write_reg(CFG_R, '0);
        send_beat(1'b0, SAMPLE_MIN);
        send_beat(1'b1, SAMPLE_MAX);
        settle();
        write_reg(CFG_R, CFG_W'(24'hFFFFFF));
        send_beat(1'b0, SAMPLE_MAX);
        // h above one is clamped on write
        settle();
        write_reg(CFG_H, 25'h1FFFFFF);
        send_beat(1'b1, SAMPLE_MIN);
        settle();
        write_reg(CFG_H, '0);
        send_beat(1'b0, SAMPLE_MAX);
        // unused indexes leave every register alone
        settle();
        write_reg(CIDX_W'(CFG_H + 1), 25'h1555555);
        write_reg(CIDX_W'(CFG_H + 3), 25'h0AAAAAA);
        send_beat(1'b1, SAMPLE_MIN);

        while (sent < 325) run_phase($urandom_range(20, 60));
        send_idle = 50;
        recv_idle = 17;
        while (sent < 650) run_phase($urandom_range(20, 60));
        send_idle = 0;
        recv_idle = 0;
        while (sent < 975) run_phase($urandom_range(20, 60));

        settle();
        recv_idle = 0;
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("%0d samples sent, %0d output beats checked, %0d register writes",
                 sent, checked, writes);
        $display("stage counts 0 to 15, all responses, stable and raw coefficients, three stall profiles");
        if (mismatches == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
